// File: src/srmq_pkg.sv
// Shared types and codes for the sparse-table range-minimum engine.
package srmq_pkg;

  // Command carried in the input tuser
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Result status carried in the output tuser
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    JOB_REPORT = 2'd0,
    JOB_APPEND = 2'd1,
    JOB_QUERY  = 2'd2
  } job_op_t;

  typedef struct packed {
    job_op_t op;
    status_t status;
  } job_ctl_t;

  localparam int JOB_CTL_W = $bits(job_ctl_t);

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_APP_RD,
    BK_APP_WAIT,
    BK_QRY_WAIT
  } back_state_t;

  // Fixed widths of the stream fields
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 10;
  localparam int MIN_W    = 32;
  localparam int IN_DATA_W  = 56;
  localparam int LEN_W      = INDEX_W + 1;
  localparam int KRAW_W     = 5;

endpackage

// File: src/srmq_front.sv
// Front end: accepts command words, checks them, tracks the element count and queues jobs.
module srmq_front
  import srmq_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_DATA_W-1:0]            in_tdata,
  input  logic [1:0]                      in_tuser,
  input  logic                            q_full,
  output logic                            q_push,
  output job_ctl_t                        job_ctl,
  output logic [$clog2(LEVELS)-1:0]       job_lvl,
  output logic [$clog2(MAX_ELEMENTS)-1:0] job_idx_a,
  output logic [$clog2(MAX_ELEMENTS)-1:0] job_idx_b,
  output logic [DATA_WIDTH-1:0]           job_value
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int LW = $clog2(LEVELS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int QW = (CW > INDEX_W) ? CW : INDEX_W;

  logic [CW-1:0]           count_r, count_nxt;
  cmd_t                    cmd;
  logic signed [VALUE_W-1:0] in_value;
  logic [INDEX_W-1:0]      in_left, in_right;
  logic [QW-1:0]           left_q, right_q, count_q;
  logic                    range_bad, store_full;
  logic [LEN_W-1:0]        len;
  logic [KRAW_W-1:0]       k_raw, k_sat;
  logic [LEN_W-1:0]        start_b;
  logic                    accept;

  // Unpack the input word
  assign cmd      = cmd_t'(in_tuser);
  assign in_value = $signed(in_tdata[VALUE_W-1:0]);
  assign in_left  = in_tdata[VALUE_W+INDEX_W-1:VALUE_W];
  assign in_right = in_tdata[VALUE_W+2*INDEX_W-1:VALUE_W+INDEX_W];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept;

  // Range checks against the current count
  assign left_q     = QW'(in_left);
  assign right_q    = QW'(in_right);
  assign count_q    = QW'(count_r);
  assign range_bad  = (left_q > right_q) || (right_q >= count_q);
  assign store_full = (count_r == CW'(MAX_ELEMENTS));

  // Window level: highest set bit of the range length, held below LEVELS
  assign len = {1'b0, in_right} - {1'b0, in_left} + LEN_W'(1);

  always_comb begin
    k_raw = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (len[i]) begin
        k_raw = KRAW_W'(i);
      end
    end
    k_sat = (k_raw > KRAW_W'(LEVELS - 1)) ? KRAW_W'(LEVELS - 1) : k_raw;
  end

  assign start_b = {1'b0, in_right} + LEN_W'(1) - (LEN_W'(1) << k_sat);

  // Classify the word into a job
  always_comb begin
    job_ctl.op     = JOB_REPORT;
    job_ctl.status = ST_OK;
    job_lvl        = LW'(k_sat);
    job_idx_a      = AW'(in_left);
    job_idx_b      = AW'(start_b);
    job_value      = DATA_WIDTH'(in_value);
    count_nxt      = count_r;
    unique case (cmd)
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      CMD_APPEND: begin
        if (store_full) begin
          job_ctl.status = ST_FULL;
        end else begin
          job_ctl.op = JOB_APPEND;
          job_idx_a  = count_r[AW-1:0];
          count_nxt  = count_r + CW'(1);
        end
      end
      CMD_QUERY: begin
        if (range_bad) begin
          job_ctl.status = ST_RANGE;
        end else begin
          job_ctl.op = JOB_QUERY;
        end
      end
      CMD_NONE: begin
        job_ctl.status = ST_OK;
      end
    endcase
  end

  // Advance the element count on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

endmodule

// File: src/srmq_queue.sv
// Short job queue between the front end and the back end.
module srmq_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    fill_r;
  logic             do_push, do_pop;

  assign full      = (fill_r == NW'(DEPTH));
  assign empty     = (fill_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = slot_r[rd_ptr_r];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + NW'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - NW'(1);
      end
    end
  end

endmodule

// File: src/srmq_back.sv
// Back end: window-minimum table, append and query sequencer, output register.
module srmq_back
  import srmq_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            job_valid,
  output logic                            job_pop,
  input  job_ctl_t                        job_ctl,
  input  logic [$clog2(LEVELS)-1:0]       job_lvl,
  input  logic [$clog2(MAX_ELEMENTS)-1:0] job_idx_a,
  input  logic [$clog2(MAX_ELEMENTS)-1:0] job_idx_b,
  input  logic [DATA_WIDTH-1:0]           job_value,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [MIN_W-1:0]                out_tdata,
  output logic [1:0]                      out_tuser
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int LW = $clog2(LEVELS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int JW = $clog2(LEVELS + 1);

  logic [DATA_WIDTH-1:0] win_min_r [LEVELS][MAX_ELEMENTS];
  logic [DATA_WIDTH-1:0] rd_a_r, rd_b_r, pair_min;

  back_state_t   state_r, state_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic [JW-1:0] j_r, j_nxt;

  logic                  wr_en, rd_en;
  logic [LW-1:0]         wr_lvl, rd_lvl;
  logic [AW-1:0]         wr_idx, rd_idx_a, rd_idx_b;
  logic [DATA_WIDTH-1:0] wr_data;

  logic [CW-1:0] n_plus1, win_start, half_start;
  logic          app_done;

  logic             out_valid_r, out_free, load;
  logic [MIN_W-1:0] out_min_r, load_min;
  status_t          out_status_r, load_status;

  // Smaller of the two registered table reads
  assign pair_min = ($signed(rd_a_r) <= $signed(rd_b_r)) ? rd_a_r : rd_b_r;

  // Window positions for the level being filled
  assign n_plus1    = CW'(n_r) + CW'(1);
  assign win_start  = n_plus1 - (CW'(1) << j_r);
  assign half_start = n_plus1 - (CW'(1) << (j_r - JW'(1)));
  assign app_done   = (j_r >= JW'(LEVELS)) || ((n_plus1 >> j_r) == '0);

  assign out_free = !out_valid_r || out_tready;

  // Sequence appends and queries
  always_comb begin
    state_nxt   = state_r;
    job_pop     = 1'b0;
    n_nxt       = n_r;
    j_nxt       = j_r;
    wr_en       = 1'b0;
    wr_lvl      = '0;
    wr_idx      = job_idx_a;
    wr_data     = job_value;
    rd_en       = 1'b0;
    rd_lvl      = job_lvl;
    rd_idx_a    = job_idx_a;
    rd_idx_b    = job_idx_b;
    load        = 1'b0;
    load_min    = '0;
    load_status = ST_OK;
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          case (job_ctl.op)
            JOB_REPORT: begin
              if (out_free) begin
                job_pop     = 1'b1;
                load        = 1'b1;
                load_status = job_ctl.status;
              end
            end
            JOB_APPEND: begin
              job_pop   = 1'b1;
              wr_en     = 1'b1;
              n_nxt     = job_idx_a;
              j_nxt     = JW'(1);
              state_nxt = BK_APP_RD;
            end
            JOB_QUERY: begin
              job_pop   = 1'b1;
              rd_en     = 1'b1;
              state_nxt = BK_QRY_WAIT;
            end
            default: begin
              job_pop = 1'b1;
            end
          endcase
        end
      end
      BK_APP_RD: begin
        if (app_done) begin
          if (out_free) begin
            load      = 1'b1;
            state_nxt = BK_IDLE;
          end
        end else begin
          rd_en     = 1'b1;
          rd_lvl    = LW'(j_r - JW'(1));
          rd_idx_a  = AW'(win_start);
          rd_idx_b  = AW'(half_start);
          state_nxt = BK_APP_WAIT;
        end
      end
      BK_APP_WAIT: begin
        wr_en     = 1'b1;
        wr_lvl    = LW'(j_r);
        wr_idx    = AW'(win_start);
        wr_data   = pair_min;
        j_nxt     = j_r + JW'(1);
        state_nxt = BK_APP_RD;
      end
      BK_QRY_WAIT: begin
        if (out_free) begin
          load      = 1'b1;
          load_min  = MIN_W'($signed(pair_min));
          state_nxt = BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the position of the append in progress
  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    j_r <= j_nxt;
  end

  // Window-minimum table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_min_r[wr_lvl][wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= win_min_r[rd_lvl][rd_idx_a];
      rd_b_r <= win_min_r[rd_lvl][rd_idx_b];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_min_r    <= load_min;
      out_status_r <= load_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_min_r;
  assign out_tuser  = out_status_r;

endmodule

// File: src/sparse_table_range_min.sv
// Sparse-table range-minimum engine over signed values, top level.
//
// Each input word carries a command in tuser (clear, append, range-minimum
// query) and gets exactly one output word: the minimum (zero unless a valid
// query) and a status (ok, range invalid, store full). The front end checks
// each word as it is accepted and keeps the element count; a two-entry job queue
// lets it take further words while the back end works. The back end owns the
// window-minimum table (one write port, two registered read ports). A query
// reads two table entries and passes the smaller on; a clear, no-op or rejected
// word goes straight to the output; an append writes the new element at index
// n, then fills m = min(floor(log2(n+1)), LEVELS-1) higher levels, and each
// level costs one table read and one table write. Results leave through a
// register and flow as soon as the output side takes them.
module sparse_table_range_min
  import srmq_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // value[31:0], left[41:32], right[51:42], zero[55:52]
  input  logic [1:0]           in_tuser,   // command[1:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [MIN_W-1:0]     out_tdata,  // minimum[31:0]
  output logic [1:0]           out_tuser   // status[1:0]
);

  localparam int AW    = $clog2(MAX_ELEMENTS);
  localparam int LW    = $clog2(LEVELS);
  localparam int JOB_W = JOB_CTL_W + LW + 2 * AW + DATA_WIDTH;

  logic                  q_full, q_empty, q_push, q_pop;
  job_ctl_t              f_ctl, b_ctl;
  logic [LW-1:0]         f_lvl, b_lvl;
  logic [AW-1:0]         f_idx_a, f_idx_b, b_idx_a, b_idx_b;
  logic [DATA_WIDTH-1:0] f_value, b_value;
  logic [JOB_W-1:0]      q_in, q_head;

  srmq_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .job_ctl   (f_ctl),
    .job_lvl   (f_lvl),
    .job_idx_a (f_idx_a),
    .job_idx_b (f_idx_b),
    .job_value (f_value)
  );

  // Pack and unpack jobs across the queue
  assign q_in = {f_ctl, f_lvl, f_idx_a, f_idx_b, f_value};
  assign {b_ctl, b_lvl, b_idx_a, b_idx_b, b_value} = q_head;

  srmq_queue #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head_data (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  srmq_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (!q_empty),
    .job_pop    (q_pop),
    .job_ctl    (b_ctl),
    .job_lvl    (b_lvl),
    .job_idx_a  (b_idx_a),
    .job_idx_b  (b_idx_b),
    .job_value  (b_value),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: dv/sparse_table_range_min_tb.sv
// Self-checking testbench for the sparse-table range-minimum engine.
`timescale 1ns / 1ps

module sparse_table_range_min_tb;
  import srmq_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int ITEM_TARGET = 1550;
  localparam int IDLE_LIMIT  = 5000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 60;

  // Track the stored elements and the results still owed by the block
  class range_min_scoreboard;
    logic signed [31:0] elements [STORE_DEPTH];
    int unsigned        n_stored;
    logic signed [31:0] expected_minima [$];
    status_t            expected_status [$];
    int                 errors;

    function new();
      n_stored = 0;
      errors   = 0;
    endfunction

    function int pending();
      return expected_minima.size();
    endfunction

    // Work out the answer to an accepted word and queue it
    function void note_request(cmd_t cmd, logic signed [31:0] value, logic [9:0] left,
                               logic [9:0] right);
      logic signed [31:0] least;
      status_t            st;
      int unsigned        idx;
      least = '0;
      st    = ST_OK;
      case (cmd)
        CMD_CLEAR: begin
          n_stored = 0;
        end
        CMD_APPEND: begin
          if (n_stored >= STORE_DEPTH) begin
            st = ST_FULL;
          end else begin
            elements[n_stored] = value;
            n_stored++;
          end
        end
        CMD_QUERY: begin
          if (left > right || right >= n_stored) begin
            st = ST_RANGE;
          end else begin
            // Plain scan over the range; independent of the table layout
            least = elements[left];
            for (idx = left + 1; idx <= right; idx++) begin
              if (elements[idx] < least) least = elements[idx];
            end
          end
        end
        default: ;
      endcase
      expected_minima = {expected_minima, least};
      expected_status = {expected_status, st};
    endfunction

    // Compare one output word with the oldest expectation
    function void check_result(logic [31:0] got_min, logic [1:0] got_status);
      logic signed [31:0] want_min;
      status_t            want_status;
      if (expected_minima.size() == 0) begin
        $display("%0t: unexpected output word, minimum %0d status %0d", $time,
                 $signed(got_min), got_status);
        errors++;
      end else begin
        want_min    = expected_minima.pop_front();
        want_status = expected_status.pop_front();
        if (got_min !== want_min) begin
          $display("%0t: minimum mismatch, expected %0d, actual %0d", $time, want_min,
                   $signed(got_min));
          errors++;
        end
        if (got_status !== want_status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time, want_status,
                   got_status);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;   // value[31:0], left[41:32], right[51:42], zero[55:52]
  logic [1:0]  in_tuser   = CMD_NONE;   // command[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // minimum[31:0]
  logic [1:0]  out_tuser;         // status[1:0]

  range_min_scoreboard sb;
  int   words_sent    = 0;
  int   burst_left    = 0;
  logic long_hold_req = 1'b0;
  int   hold_left     = 0;
  int   mode_left     = 0;
  int   rx_mode       = 0;
  int   idle_cycles   = 0;

  sparse_table_range_min #(
    .MAX_ELEMENTS(STORE_DEPTH),
    .LEVELS      (11),
    .DATA_WIDTH  (32)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Offer one word, hold it until taken, then maybe end the burst
  task automatic send_word(input cmd_t cmd, input logic [31:0] value, input logic [9:0] left,
                           input logic [9:0] right);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, right, left, value};
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(cmd, value, left, right);
    if (cmd != CMD_NONE) words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait for every owed word to come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      1:       return 32'($urandom_range(0, 32)) - 32'd16;
      default: return $urandom;
    endcase
  endfunction

  // Query inside the stored range, mostly short spans
  task automatic query_valid();
    int unsigned n;
    int unsigned left;
    int unsigned right;
    n = sb.n_stored;
    if (n == 0) begin
      send_word(CMD_QUERY, $urandom, 10'd0, 10'd0);
    end else begin
      left = $urandom_range(0, n - 1);
      if ($urandom_range(0, 2) == 0) begin
        right = $urandom_range(left, n - 1);
      end else begin
        right = left + $urandom_range(0, 7);
        if (right > n - 1) right = n - 1;
      end
      send_word(CMD_QUERY, $urandom, left[9:0], right[9:0]);
    end
  endtask

  task automatic query_any();
    send_word(CMD_QUERY, $urandom, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
  endtask

  task automatic append_one();
    send_word(CMD_APPEND, pick_value(), 10'($urandom), 10'($urandom));
  endtask

  // Stimulus
  initial begin
    int n_app;
    int n_qry;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, each command, empty store, bad ranges, reuse after clear
    send_word(CMD_QUERY, 32'd0, 10'd0, 10'd0);
    send_word(CMD_APPEND, 32'h7fff_ffff, 10'd0, 10'd0);
    send_word(CMD_APPEND, 32'h8000_0000, 10'h3ff, 10'h3ff);
    send_word(CMD_APPEND, 32'h0000_0000, 10'd0, 10'd0);
    send_word(CMD_APPEND, 32'hffff_ffff, 10'd0, 10'd0);
    send_word(CMD_APPEND, 32'h0000_0001, 10'd0, 10'd0);
    send_word(CMD_QUERY, 32'd0, 10'd0, 10'd0);
    send_word(CMD_QUERY, 32'hffff_ffff, 10'd0, 10'd4);
    send_word(CMD_QUERY, 32'd0, 10'd2, 10'd4);
    send_word(CMD_QUERY, 32'd0, 10'd4, 10'd4);
    send_word(CMD_QUERY, 32'd0, 10'd3, 10'd1);
    send_word(CMD_QUERY, 32'd0, 10'd0, 10'd5);
    send_word(CMD_QUERY, 32'd0, 10'h3ff, 10'h3ff);
    send_word(CMD_NONE, 32'hffff_ffff, 10'h3ff, 10'h3ff);
    send_word(CMD_CLEAR, 32'hffff_ffff, 10'h3ff, 10'h3ff);
    send_word(CMD_QUERY, 32'd0, 10'd0, 10'd0);
    send_word(CMD_APPEND, 32'd5, 10'd0, 10'd0);
    send_word(CMD_APPEND, -32'sd3, 10'd0, 10'd0);
    send_word(CMD_QUERY, 32'd0, 10'd0, 10'd1);
    send_word(CMD_QUERY, 32'd0, 10'd1, 10'd1);
    drain();

    // Fill the whole store, with a long receiver hold-off at the start
    long_hold_req = 1'b1;
    send_word(CMD_CLEAR, $urandom, 10'($urandom), 10'($urandom));
    while (sb.n_stored < STORE_DEPTH) begin
      append_one();
      if ($urandom_range(0, 15) == 0) query_valid();
    end
    repeat (3) append_one();
    send_word(CMD_QUERY, $urandom, 10'd0, 10'h3ff);
    send_word(CMD_QUERY, $urandom, 10'h3ff, 10'h3ff);
    send_word(CMD_QUERY, $urandom, 10'h200, 10'h3ff);
    send_word(CMD_QUERY, $urandom, 10'h3ff, 10'd0);
    repeat (20) query_valid();
    drain();

    // Random sequences: mostly clear, appends, queries; some noise
    while (words_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 1) == 0) send_word(CMD_CLEAR, $urandom, 10'($urandom),
                                                 10'($urandom));
        n_app = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
        repeat (n_app) append_one();
        n_qry = $urandom_range(1, 12);
        repeat (n_qry) begin
          case ($urandom_range(0, 7))
            0:       query_any();
            1:       append_one();
            default: query_valid();
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_word(cmd_t'($urandom_range(0, 3)), $urandom, 10'($urandom), 10'($urandom));
        end
      end
      if ($urandom_range(0, 15) == 0) drain();
    end

    // Wind down
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sparse_table_range_min_tb passed");
    end else begin
      $display("sparse_table_range_min_tb failed");
    end
    $finish;
  end

  // Receiver: check taken words, stall on a changing pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          2:       out_tready <= ($urandom_range(0, 1) == 0);
          3:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= 1'b1;
        endcase
      end
    end
  end

  // Watchdog: end the run if no word moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("sparse_table_range_min_tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// File: filelist.f
src/srmq_pkg.sv
src/srmq_front.sv
src/srmq_queue.sv
src/srmq_back.sv
src/sparse_table_range_min.sv
dv/sparse_table_range_min_tb.sv
